FILE: rtl/core/rmgr_pkg.sv
package rmgr_pkg;

   // Fixed field widths of the channels
   localparam int FIELD_BITS = 32;
   localparam int COUNT_BITS = 7;
   localparam int GAP_BITS   = 32;

   // Token that walks down the cell chain for one stored number
   typedef struct packed {
      logic                active;
      logic [GAP_BITS-1:0] gap;
   } rmgr_tok_type;

endpackage

FILE: rtl/core/rmgr_req_if.sv
interface rmgr_req_if import rmgr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [FIELD_BITS-1:0] new_value;

   modport source (output valid, output new_value, input ready);
   modport sink   (input valid, input new_value, output ready);
endinterface

FILE: rtl/core/rmgr_rsp_if.sv
interface rmgr_rsp_if import rmgr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic                  full_error;
   logic [COUNT_BITS-1:0] held_count;
   logic                  spans_valid;
   logic [GAP_BITS-1:0]   shortest_span;
   logic [GAP_BITS-1:0]   longest_span;

   modport source (output valid, output accepted, output full_error, output held_count,
                   output spans_valid, output shortest_span, output longest_span,
                   input ready);
   modport sink   (input valid, input accepted, input full_error, input held_count,
                   input spans_valid, input shortest_span, input longest_span,
                   output ready);
endinterface

FILE: rtl/core/rmgr_cell.sv
module rmgr_cell import rmgr_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_BITS-1:0] count_i,
   input  logic                  wr_en_i,
   input  logic [VALUE_BITS-1:0] wr_value_i,
   input  logic [VALUE_BITS-1:0] probe_i,
   input  rmgr_tok_type          tok_i,
   output rmgr_tok_type          tok_o
);

   logic [VALUE_BITS-1:0] value_ff;
   logic                  live;
   logic signed [VALUE_BITS:0] diff;
   logic [VALUE_BITS:0]   mag;
   logic [GAP_BITS-1:0]   gap_val;
   rmgr_tok_type          tok_ff;
   rmgr_tok_type          tok_in;

   // Cell holds an entry once the count has passed its slot
   assign live = int'(count_i) > CELL_INDEX;

   // Distance between the probe and the held entry
   always_comb begin
      diff = $signed({probe_i[VALUE_BITS-1], probe_i})
           - $signed({value_ff[VALUE_BITS-1], value_ff});
      mag     = diff[VALUE_BITS] ? $unsigned(-diff) : $unsigned(diff);
      gap_val = GAP_BITS'(mag[VALUE_BITS-1:0]);
   end

   // Fold the distance into the passing token
   always_comb begin
      tok_in = tok_i;
      if (tok_i.active && live && (gap_val < tok_i.gap)) begin
         tok_in.gap = gap_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in.active;
      end
      tok_ff.gap <= tok_in.gap;
   end

   // Store slot is written when the count points at it
   always_ff @(posedge clock) begin
      if (wr_en_i && (int'(count_i) == CELL_INDEX)) begin
         value_ff <= wr_value_i;
      end
   end

   assign tok_o = tok_ff;

endmodule

FILE: rtl/core/running_min_gap_and_range_core.sv
// Running closest pair and range of a set of signed numbers. Each beat on
// req_bus carries one number (low VALUE_BITS bits, sign-extended); the core
// stores it while the count is below min(capacity_limit, CAPACITY), else
// rejects it with full_error, and returns one rsp_bus beat with the count,
// the shortest gap between held numbers and the span greatest minus least.
// The new number is compared against the store by a token that walks a
// chain of CAPACITY cells, one cell per clock; a rejected number skips
// the chain. One number is in work at a time; a finished beat waiting on
// rsp_bus does not hold off the next req_bus beat, but that number's
// result waits until the pending beat drains.
// csr_wr_data is the capacity limit; write it only while the core is idle.
module running_min_gap_and_range_core import rmgr_pkg::*; #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   rmgr_req_if.sink              req_bus,
   rmgr_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } rmgr_state_type;

   rmgr_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]        limit_ff;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [VALUE_BITS-1:0] least_ff, least_in;
   logic signed [VALUE_BITS-1:0] greatest_ff, greatest_in;
   logic [GAP_BITS-1:0]          min_gap_ff, min_gap_in;
   logic [VALUE_BITS-1:0]        x_ff;
   logic                         acc_ff, acc_in;
   logic [GAP_BITS-1:0]          gap_res_ff, gap_res_in;
   logic                         inj_ff, inj_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_acc_ff;
   logic [COUNT_BITS-1:0]        rsp_count_ff;
   logic                         rsp_spans_ff;
   logic [GAP_BITS-1:0]          rsp_short_ff;
   logic [GAP_BITS-1:0]          rsp_long_ff;

   logic                  req_beat;
   logic                  room;
   logic                  load;
   logic [VALUE_BITS-1:0] req_x;
   logic                  spans;
   logic [VALUE_BITS-1:0] span_raw;

   rmgr_tok_type tok [0:CAPACITY];

   assign req_x    = req_bus.new_value[VALUE_BITS-1:0];
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_beat = req_bus.valid && req_bus.ready;

   // Room left: below the written limit and below the physical store
   assign room = (count_ff < limit_ff) && (int'(count_ff) < CAPACITY);

   // Result register takes the pending beat when it is free or draining
   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   // Token entering the chain
   assign tok[0] = {inj_ff, min_gap_ff};

   generate
      for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
         rmgr_cell #(
            .CELL_INDEX (gi),
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .count_i    (count_ff),
            .wr_en_i    (req_beat && room),
            .wr_value_i (req_x),
            .probe_i    (x_ff),
            .tok_i      (tok[gi]),
            .tok_o      (tok[gi+1])
         );
      end
   endgenerate

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      acc_in     = acc_ff;
      gap_res_in = gap_res_ff;
      inj_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               acc_in     = room;
               gap_res_in = min_gap_ff;
               if (room) begin
                  inj_in   = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (tok[CAPACITY].active) begin
               gap_res_in = tok[CAPACITY].gap;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State after this number
   always_comb begin
      count_in    = count_ff;
      least_in    = least_ff;
      greatest_in = greatest_ff;
      min_gap_in  = min_gap_ff;
      if (acc_ff) begin
         count_in   = count_ff + 1'b1;
         min_gap_in = gap_res_ff;
         if (count_ff == '0) begin
            least_in    = $signed(x_ff);
            greatest_in = $signed(x_ff);
         end else begin
            if ($signed(x_ff) < least_ff) begin
               least_in = $signed(x_ff);
            end
            if ($signed(x_ff) > greatest_ff) begin
               greatest_in = $signed(x_ff);
            end
         end
      end
      spans    = (count_in >= COUNT_BITS'(2));
      span_raw = VALUE_BITS'(greatest_in - least_in);
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= '0;
         count_ff     <= '0;
         least_ff     <= '0;
         greatest_ff  <= '0;
         min_gap_ff   <= '1;
         inj_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inj_ff       <= inj_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (load) begin
            count_ff    <= count_in;
            least_ff    <= least_in;
            greatest_ff <= greatest_in;
            min_gap_ff  <= min_gap_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      gap_res_ff <= gap_res_in;
      if (req_beat) begin
         x_ff <= req_x;
      end
      if (load) begin
         rsp_acc_ff   <= acc_ff;
         rsp_count_ff <= count_in;
         rsp_spans_ff <= spans;
         rsp_short_ff <= spans ? min_gap_in : '0;
         rsp_long_ff  <= spans ? GAP_BITS'(span_raw) : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.accepted      = rsp_acc_ff;
   assign rsp_bus.full_error    = !rsp_acc_ff;
   assign rsp_bus.held_count    = rsp_count_ff;
   assign rsp_bus.spans_valid   = rsp_spans_ff;
   assign rsp_bus.shortest_span = rsp_short_ff;
   assign rsp_bus.longest_span  = rsp_long_ff;

endmodule

FILE: verif/tb.sv
module tb;
   import rmgr_pkg::*;

   localparam int SLOT_COUNT    = 64;
   // one stored number walks the whole cell chain, plus some margin
   localparam int SETTLE_CYCLES = SLOT_COUNT + 16;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic                  accepted;
      logic                  full_error;
      logic [COUNT_BITS-1:0] held_count;
      logic                  spans_valid;
      logic [GAP_BITS-1:0]   shortest_span;
      logic [GAP_BITS-1:0]   longest_span;
   } span_result_type;

   // Tracks the held set, predicts each result and checks the rsp beats
   class span_board;
      logic [COUNT_BITS-1:0] capacity_limit;
      longint                held_values[SLOT_COUNT];
      int                    count_held;
      longint                least_value;
      longint                greatest_value;
      logic [GAP_BITS-1:0]   min_gap;
      span_result_type       expected_spans[$];
      int                    fail_count;

      function new();
         capacity_limit = '0;
         count_held     = 0;
         least_value    = 0;
         greatest_value = 0;
         min_gap        = '1;
         fail_count     = 0;
      endfunction

      function void set_limit(logic [COUNT_BITS-1:0] limit);
         capacity_limit = limit;
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction

      // Accepted req beat: update the held set and queue the expected result
      function void note_value(logic signed [FIELD_BITS-1:0] raw);
         longint          x;
         longint          gap;
         int              cap;
         int              i;
         span_result_type r;
         x   = longint'(raw);
         cap = (capacity_limit > SLOT_COUNT) ? SLOT_COUNT : int'(capacity_limit);
         r.accepted = (count_held < cap);
         if (r.accepted) begin
            if (count_held == 0) begin
               least_value    = x;
               greatest_value = x;
            end else begin
               // an insert can only shrink the closest gap
               for (i = 0; i < count_held; i++) begin
                  gap = (x >= held_values[i]) ? x - held_values[i] : held_values[i] - x;
                  if (gap < longint'(min_gap))
                     min_gap = gap[GAP_BITS-1:0];
               end
               if (x < least_value)
                  least_value = x;
               if (x > greatest_value)
                  greatest_value = x;
            end
            held_values[count_held] = x;
            count_held++;
         end
         r.full_error  = !r.accepted;
         r.held_count  = count_held[COUNT_BITS-1:0];
         r.spans_valid = (count_held >= 2);
         gap = greatest_value - least_value;
         r.shortest_span = r.spans_valid ? min_gap : '0;
         r.longest_span  = r.spans_valid ? gap[GAP_BITS-1:0] : '0;
         expected_spans = {expected_spans, r};
      endfunction

      function void compare_field(string name, logic [GAP_BITS-1:0] want,
                                  logic [GAP_BITS-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_result(span_result_type got);
         span_result_type want;
         if (expected_spans.size() == 0) begin
            $error("rsp beat with no pending expectation");
            fail_count++;
            return;
         end
         want = expected_spans.pop_front();
         compare_field("accepted", GAP_BITS'(want.accepted), GAP_BITS'(got.accepted));
         compare_field("full_error", GAP_BITS'(want.full_error),
                       GAP_BITS'(got.full_error));
         compare_field("held_count", GAP_BITS'(want.held_count),
                       GAP_BITS'(got.held_count));
         compare_field("spans_valid", GAP_BITS'(want.spans_valid),
                       GAP_BITS'(got.spans_valid));
         compare_field("shortest_span", want.shortest_span, got.shortest_span);
         compare_field("longest_span", want.longest_span, got.longest_span);
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0]        csr_wr_data = '0;
   logic                         send_valid = 1'b0;
   logic signed [FIELD_BITS-1:0] send_data = '0;
   logic                         rsp_take = 1'b0;
   int                           send_idle_pct = 11;
   int                           recv_idle_pct = 69;
   int                           cycle_count = 0;
   span_board                    board = new();

   rmgr_req_if req_bus();
   rmgr_rsp_if rsp_bus();

   assign req_bus.valid     = send_valid;
   assign req_bus.new_value = send_data;
   assign rsp_bus.ready     = rsp_take;

   running_min_gap_and_range_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side: check each beat, then stall at random
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result('{rsp_bus.accepted, rsp_bus.full_error, rsp_bus.held_count,
                              rsp_bus.spans_valid, rsp_bus.shortest_span,
                              rsp_bus.longest_span});
      rsp_take <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One req beat, with random idle cycles ahead of it
   task automatic offer_value(input logic signed [FIELD_BITS-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         send_valid <= 1'b0;
         @(posedge clock);
      end
      send_valid <= 1'b1;
      send_data  <= v;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      board.note_value(v);
   endtask

   // Drop valid and wait until every queued result has come back
   task automatic hold_until_drained();
      send_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.pending() != 0);
   endtask

   // Capacity writes happen only with the core idle
   task automatic write_limit(input logic [COUNT_BITS-1:0] limit);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_limit(limit);
   endtask

   // Random numbers: scaled randoms and near neighbors of held numbers while
   // there is room, full-range noise once the store is full
   task automatic run_random(input int beats, input int shift_floor);
      logic signed [FIELD_BITS-1:0] v;
      longint                       near;
      int                           offset;
      int                           k;
      for (k = 0; k < beats; k++) begin
         if ($urandom_range(49) == 0)
            hold_until_drained();
         v = $urandom;
         if (board.count_held < board.capacity_limit) begin
            if (board.count_held > 0 && $urandom_range(2) == 0) begin
               offset = $urandom_range(32, 1);
               if ($urandom_range(1) == 1)
                  offset = -offset;
               near = board.held_values[$urandom_range(board.count_held - 1)] + offset;
               v = near[FIELD_BITS-1:0];
            end else begin
               v = v >>> $urandom_range(28, shift_floor);
            end
         end
         offer_value(v);
      end
   endtask

   initial begin
      longint dup;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // capacity zero after reset: everything rejected
      offer_value(32'sh7FFF_FFFF);
      offer_value(32'sh8000_0000);
      // single slot: one store, then full
      write_limit(7'd1);
      offer_value(5);
      offer_value(0);
      // spans become valid at two held numbers
      write_limit(7'd3);
      offer_value(-3);
      offer_value(100);
      offer_value(-1);
      // limit lowered below the count keeps the store full
      write_limit(7'd2);
      offer_value(32'sh5555_5555);
      offer_value(32'shAAAA_AAAA);

      write_limit(7'd30);
      run_random(165, 12);

      send_idle_pct = 69;
      recv_idle_pct = 11;
      write_limit(7'd50);
      run_random(165, 6);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(7'd61);
      run_random(165, 0);

      // extremes: most negative number, a repeated number, saturated limit
      write_limit(7'd64);
      offer_value(32'sh8000_0000);
      dup = board.held_values[$urandom_range(board.count_held - 1)];
      offer_value(dup[FIELD_BITS-1:0]);
      write_limit(7'd127);
      offer_value(32'sh7FFF_FFFF);
      offer_value(1);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.fail_count == 0 && board.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
